/* hw/rtl/svm_pkg.sv */
// Package for the stack machine step block: transaction types, status and opcode codes.
// No dependencies.
package svm_pkg;

   typedef struct packed {
      logic [1:0]         action;
      logic [11:0]        word_index;
      logic signed [63:0] word_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [63:0] accumulator;
      logic [14:0]        program_counter;
      logic [15:0]        stack_pointer;
      logic signed [63:0] exit_value;
   } rsp_type;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_EXEC  = 2'd2;

   localparam logic [1:0] CSR_ENTRY = 2'd0;
   localparam logic [1:0] CSR_STACK = 2'd1;

   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_EXIT    = 3'd1;
   localparam logic [2:0] ST_BADOP   = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_SYSCALL = 3'd4;
   localparam logic [2:0] ST_FAULT   = 3'd5;

   localparam logic [5:0] OP_LEA  = 6'd0;
   localparam logic [5:0] OP_IMM  = 6'd1;
   localparam logic [5:0] OP_JMP  = 6'd2;
   localparam logic [5:0] OP_CALL = 6'd3;
   localparam logic [5:0] OP_JZ   = 6'd4;
   localparam logic [5:0] OP_JNZ  = 6'd5;
   localparam logic [5:0] OP_ENT  = 6'd6;
   localparam logic [5:0] OP_ADJ  = 6'd7;
   localparam logic [5:0] OP_LEV  = 6'd8;
   localparam logic [5:0] OP_LI   = 6'd9;
   localparam logic [5:0] OP_LC   = 6'd10;
   localparam logic [5:0] OP_SI   = 6'd11;
   localparam logic [5:0] OP_SC   = 6'd12;
   localparam logic [5:0] OP_PUSH = 6'd13;
   localparam logic [5:0] OP_OR   = 6'd14;
   localparam logic [5:0] OP_XOR  = 6'd15;
   localparam logic [5:0] OP_AND  = 6'd16;
   localparam logic [5:0] OP_EQ   = 6'd17;
   localparam logic [5:0] OP_NE   = 6'd18;
   localparam logic [5:0] OP_LT   = 6'd19;
   localparam logic [5:0] OP_GT   = 6'd20;
   localparam logic [5:0] OP_LE   = 6'd21;
   localparam logic [5:0] OP_GE   = 6'd22;
   localparam logic [5:0] OP_SHL  = 6'd23;
   localparam logic [5:0] OP_SHR  = 6'd24;
   localparam logic [5:0] OP_ADD  = 6'd25;
   localparam logic [5:0] OP_SUB  = 6'd26;
   localparam logic [5:0] OP_MUL  = 6'd27;
   localparam logic [5:0] OP_DIV  = 6'd28;
   localparam logic [5:0] OP_MOD  = 6'd29;
   localparam logic [5:0] OP_OPEN = 6'd30;
   localparam logic [5:0] OP_MCMP = 6'd36;
   localparam logic [5:0] OP_EXIT = 6'd37;

endpackage

/* hw/rtl/stack_vm_instruction_step_top.sv */
// Top level of the stack machine step block: sequencer, word memory, shared mul/div unit.
// Depends on svm_pkg.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | req_payload (req_type)
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_payload (rsp_type)
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// Preload and start pass through the done state; an instruction's steps are set by the
// single memory read port (opcode, operand, stack reads); MUL, DIV and MOD iterate
// in the shared shift/add unit. req_ready is high only in the idle state.
// A finished result waits in the output register while the next transaction is taken.
// Reset is synchronous and resets control and architectural registers (stack CSR to 0x8000); memory is not cleared.
module stack_vm_instruction_step_top
   import svm_pkg::*;
#(
   parameter int MEM_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(MEM_WORDS);

   typedef enum logic [3:0] {
      S_IDLE, S_OP, S_DEC, S_IMM, S_ENT, S_POP, S_SC, S_ALU, S_ITER, S_FIX,
      S_LEV1, S_LEV2, S_LD, S_EXIT, S_CHK, S_DONE
   } state_type;

   state_type   state_ff;
   logic [14:0] entry_ff;
   logic [15:0] stack_ff;
   logic [63:0] acc_ff;
   logic [14:0] pc_ff;
   logic [15:0] sp_ff, bp_ff;
   logic [2:0]  halt_ff;
   logic [63:0] ax_w_ff, pc_w_ff, sp_w_ff, bp_w_ff;
   logic [63:0] a_ff, imm_ff, ev_ff;
   logic [5:0]  op_ff;
   logic        wr_ff;
   logic [63:0] wa_ff, wv_ff;
   logic [63:0] x_ff, y_ff, z_ff;
   logic [5:0]  ctr_ff;
   logic        neg_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [63:0] mem [MEM_WORDS];
   logic [63:0] rdata_ff;
   logic [63:0] raddr;
   logic        mem_we;
   logic [63:0] mem_waddr;
   logic [63:0] mem_wdata;

   function automatic logic word_ok(input logic [63:0] a);
      return (a[2:0] == 3'd0) && ({3'd0, a[63:3]} < 64'(MEM_WORDS));
   endfunction

   function automatic logic byte_ok(input logic [63:0] a);
      return {3'd0, a[63:3]} < 64'(MEM_WORDS);
   endfunction

   function automatic logic [63:0] sext8(input logic [7:0] b);
      return {{56{b[7]}}, b};
   endfunction

   function automatic logic [63:0] magn(input logic [63:0] a);
      return a[63] ? (64'd0 - a) : a;
   endfunction

   logic        accept;
   logic [63:0] idx64;
   logic [63:0] dop;
   logic [63:0] sp_m8;
   logic [63:0] rem_sh;
   logic [63:0] byte_sh;

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign accept      = req_valid && req_ready;
   assign idx64       = 64'(req_payload.word_index);
   assign dop         = rdata_ff;
   assign sp_m8       = sp_w_ff - 64'd8;
   assign rem_sh      = {z_ff[62:0], x_ff[63]};
   assign byte_sh     = rdata_ff >> {ax_w_ff[2:0], 3'd0};

   always_comb begin
      raddr = pc_w_ff;
      case (state_ff)
         S_DEC: begin
            if (dop <= 64'(OP_ADJ)) begin
               raddr = pc_w_ff;
            end else if (dop == 64'(OP_LEV)) begin
               raddr = bp_w_ff;
            end else if (dop == 64'(OP_LI) || dop == 64'(OP_LC)) begin
               raddr = ax_w_ff;
            end else begin
               raddr = sp_w_ff;
            end
         end
         S_POP:   raddr = rdata_ff;
         S_LEV1:  raddr = sp_w_ff + 64'd8;
         default: raddr = pc_w_ff;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wa_ff;
      mem_wdata = wv_ff;
      if (accept && req_payload.action == ACT_WRITE && idx64 < 64'(MEM_WORDS)) begin
         mem_we    = 1'b1;
         mem_waddr = {idx64[60:0], 3'd0};
         mem_wdata = req_payload.word_value;
      end else if (state_ff == S_CHK && wr_ff && !(|pc_w_ff[63:15]) &&
                   !(|sp_w_ff[63:16]) && !(|bp_w_ff[63:16])) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr[AW+2:3]] <= mem_wdata;
      end
      rdata_ff <= mem[raddr[AW+2:3]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entry_ff     <= 15'd0;
         stack_ff     <= 16'h8000;
         acc_ff       <= 64'd0;
         pc_ff        <= 15'd0;
         sp_ff        <= 16'd0;
         bp_ff        <= 16'd0;
         halt_ff      <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_ENTRY: entry_ff <= csr_data[14:0];
               CSR_STACK: stack_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ev_ff    <= 64'd0;
                  wr_ff    <= 1'b0;
                  ax_w_ff  <= acc_ff;
                  pc_w_ff  <= 64'(pc_ff);
                  sp_w_ff  <= 64'(sp_ff);
                  bp_w_ff  <= 64'(bp_ff);
                  state_ff <= S_DONE;
                  if (req_payload.action == ACT_START) begin
                     pc_ff   <= entry_ff;
                     sp_ff   <= stack_ff;
                     bp_ff   <= stack_ff;
                     acc_ff  <= 64'd0;
                     halt_ff <= ST_RUN;
                  end else if (req_payload.action == ACT_EXEC && halt_ff == ST_RUN) begin
                     state_ff <= S_OP;
                  end
               end
            end
            S_OP: begin
               if (!word_ok(pc_w_ff)) begin
                  halt_ff  <= ST_FAULT;
                  state_ff <= S_DONE;
               end else begin
                  pc_w_ff  <= pc_w_ff + 64'd8;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               op_ff <= dop[5:0];
               if (dop <= 64'(OP_ADJ)) begin
                  if (!word_ok(pc_w_ff)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     pc_w_ff  <= pc_w_ff + 64'd8;
                     state_ff <= S_IMM;
                  end
               end else if (dop == 64'(OP_LEV)) begin
                  sp_w_ff <= bp_w_ff;
                  if (!word_ok(bp_w_ff) || !word_ok(bp_w_ff + 64'd8)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_LEV1;
                  end
               end else if (dop == 64'(OP_LI)) begin
                  if (!word_ok(ax_w_ff)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_LD;
                  end
               end else if (dop == 64'(OP_LC)) begin
                  if (!byte_ok(ax_w_ff)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_LD;
                  end
               end else if (dop == 64'(OP_PUSH)) begin
                  if (!word_ok(sp_m8)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     wr_ff    <= 1'b1;
                     wa_ff    <= sp_m8;
                     wv_ff    <= ax_w_ff;
                     sp_w_ff  <= sp_m8;
                     state_ff <= S_CHK;
                  end
               end else if ((dop >= 64'(OP_SI) && dop <= 64'(OP_SC)) ||
                            (dop >= 64'(OP_OR) && dop <= 64'(OP_MOD)) ||
                            dop == 64'(OP_EXIT)) begin
                  if (!word_ok(sp_w_ff)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= (dop == 64'(OP_EXIT)) ? S_EXIT : S_POP;
                  end
               end else if (dop >= 64'(OP_OPEN) && dop <= 64'(OP_MCMP)) begin
                  halt_ff  <= ST_SYSCALL;
                  state_ff <= S_DONE;
               end else begin
                  halt_ff  <= ST_BADOP;
                  state_ff <= S_DONE;
               end
            end
            S_IMM: begin
               imm_ff   <= rdata_ff;
               state_ff <= S_CHK;
               case (op_ff)
                  OP_LEA: ax_w_ff <= bp_w_ff + {rdata_ff[60:0], 3'd0};
                  OP_IMM: ax_w_ff <= rdata_ff;
                  OP_JMP: pc_w_ff <= rdata_ff;
                  OP_CALL: begin
                     if (!word_ok(sp_m8)) begin
                        halt_ff  <= ST_FAULT;
                        state_ff <= S_DONE;
                     end else begin
                        wr_ff   <= 1'b1;
                        wa_ff   <= sp_m8;
                        wv_ff   <= pc_w_ff;
                        sp_w_ff <= sp_m8;
                        pc_w_ff <= rdata_ff;
                     end
                  end
                  OP_JZ: begin
                     if (ax_w_ff == 64'd0) pc_w_ff <= rdata_ff;
                  end
                  OP_JNZ: begin
                     if (ax_w_ff != 64'd0) pc_w_ff <= rdata_ff;
                  end
                  OP_ENT: begin
                     if (!word_ok(sp_m8)) begin
                        halt_ff  <= ST_FAULT;
                        state_ff <= S_DONE;
                     end else begin
                        wr_ff    <= 1'b1;
                        wa_ff    <= sp_m8;
                        wv_ff    <= bp_w_ff;
                        bp_w_ff  <= sp_m8;
                        sp_w_ff  <= sp_m8;
                        state_ff <= S_ENT;
                     end
                  end
                  default: sp_w_ff <= sp_w_ff + {rdata_ff[60:0], 3'd0};
               endcase
            end
            S_ENT: begin
               sp_w_ff  <= sp_w_ff - {imm_ff[60:0], 3'd0};
               state_ff <= S_CHK;
            end
            S_POP: begin
               a_ff <= rdata_ff;
               if (op_ff == OP_SI) begin
                  if (!word_ok(rdata_ff)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     wr_ff    <= 1'b1;
                     wa_ff    <= {rdata_ff[63:3], 3'd0};
                     wv_ff    <= ax_w_ff;
                     sp_w_ff  <= sp_w_ff + 64'd8;
                     state_ff <= S_CHK;
                  end
               end else if (op_ff == OP_SC) begin
                  if (!byte_ok(rdata_ff)) begin
                     halt_ff  <= ST_FAULT;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SC;
                  end
               end else begin
                  sp_w_ff  <= sp_w_ff + 64'd8;
                  state_ff <= S_ALU;
               end
            end
            S_SC: begin
               wr_ff    <= 1'b1;
               wa_ff    <= {a_ff[63:3], 3'd0};
               wv_ff    <= (rdata_ff & ~(64'hff << {a_ff[2:0], 3'd0})) |
                           ({56'd0, ax_w_ff[7:0]} << {a_ff[2:0], 3'd0});
               ax_w_ff  <= sext8(ax_w_ff[7:0]);
               sp_w_ff  <= sp_w_ff + 64'd8;
               state_ff <= S_CHK;
            end
            S_ALU: begin
               state_ff <= S_CHK;
               ctr_ff   <= 6'd0;
               z_ff     <= 64'd0;
               case (op_ff)
                  OP_OR:  ax_w_ff <= a_ff | ax_w_ff;
                  OP_XOR: ax_w_ff <= a_ff ^ ax_w_ff;
                  OP_AND: ax_w_ff <= a_ff & ax_w_ff;
                  OP_EQ:  ax_w_ff <= 64'(a_ff == ax_w_ff);
                  OP_NE:  ax_w_ff <= 64'(a_ff != ax_w_ff);
                  OP_LT:  ax_w_ff <= 64'($signed(a_ff) < $signed(ax_w_ff));
                  OP_GT:  ax_w_ff <= 64'($signed(ax_w_ff) < $signed(a_ff));
                  OP_LE:  ax_w_ff <= 64'(!($signed(ax_w_ff) < $signed(a_ff)));
                  OP_GE:  ax_w_ff <= 64'(!($signed(a_ff) < $signed(ax_w_ff)));
                  OP_SHL: ax_w_ff <= a_ff << ax_w_ff[5:0];
                  OP_SHR: ax_w_ff <= 64'($signed(a_ff) >>> ax_w_ff[5:0]);
                  OP_ADD: ax_w_ff <= a_ff + ax_w_ff;
                  OP_SUB: ax_w_ff <= a_ff - ax_w_ff;
                  OP_MUL: begin
                     x_ff     <= ax_w_ff;
                     y_ff     <= a_ff;
                     state_ff <= S_ITER;
                  end
                  default: begin
                     if (ax_w_ff == 64'd0) begin
                        halt_ff  <= ST_DIVZERO;
                        state_ff <= S_DONE;
                     end else begin
                        x_ff     <= magn(a_ff);
                        y_ff     <= magn(ax_w_ff);
                        neg_ff   <= (op_ff == OP_DIV) ? (a_ff[63] ^ ax_w_ff[63]) : a_ff[63];
                        state_ff <= S_ITER;
                     end
                  end
               endcase
            end
            S_ITER: begin
               ctr_ff <= ctr_ff + 6'd1;
               if (op_ff == OP_MUL) begin
                  if (x_ff[0]) z_ff <= z_ff + y_ff;
                  x_ff <= x_ff >> 1;
                  y_ff <= y_ff << 1;
               end else if (rem_sh >= y_ff) begin
                  z_ff <= rem_sh - y_ff;
                  x_ff <= {x_ff[62:0], 1'b1};
               end else begin
                  z_ff <= rem_sh;
                  x_ff <= {x_ff[62:0], 1'b0};
               end
               if (ctr_ff == 6'd63) state_ff <= S_FIX;
            end
            S_FIX: begin
               if (op_ff == OP_MUL) begin
                  ax_w_ff <= z_ff;
               end else if (op_ff == OP_DIV) begin
                  ax_w_ff <= neg_ff ? (64'd0 - x_ff) : x_ff;
               end else begin
                  ax_w_ff <= neg_ff ? (64'd0 - z_ff) : z_ff;
               end
               state_ff <= S_CHK;
            end
            S_LEV1: begin
               bp_w_ff  <= rdata_ff;
               state_ff <= S_LEV2;
            end
            S_LEV2: begin
               pc_w_ff  <= rdata_ff;
               sp_w_ff  <= sp_w_ff + 64'd16;
               state_ff <= S_CHK;
            end
            S_LD: begin
               ax_w_ff  <= (op_ff == OP_LI) ? rdata_ff : sext8(byte_sh[7:0]);
               state_ff <= S_CHK;
            end
            S_EXIT: begin
               ev_ff    <= rdata_ff;
               halt_ff  <= ST_EXIT;
               acc_ff   <= ax_w_ff;
               pc_ff    <= pc_w_ff[14:0];
               state_ff <= S_DONE;
            end
            S_CHK: begin
               if ((|pc_w_ff[63:15]) || (|sp_w_ff[63:16]) || (|bp_w_ff[63:16])) begin
                  halt_ff <= ST_FAULT;
               end else begin
                  acc_ff <= ax_w_ff;
                  pc_ff  <= pc_w_ff[14:0];
                  sp_ff  <= sp_w_ff[15:0];
                  bp_ff  <= bp_w_ff[15:0];
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.status          <= halt_ff;
                  rsp_ff.accumulator     <= acc_ff;
                  rsp_ff.program_counter <= pc_ff;
                  rsp_ff.stack_pointer   <= sp_ff;
                  rsp_ff.exit_value      <= ev_ff;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
